// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker of the compensation unit.
// Both macros expect clk in the enclosing scope; PTC_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every rising edge outside of reset.
`define PTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define PTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/ptc_pkg.sv =====
// Package of the pressure and temperature compensation unit.
// Holds transaction and calibration types and shared constants; no dependencies.
package ptc_pkg;

  localparam int DIV_BITS = 37;
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam logic [24:0] PRESS_MAX = 25'h1FF_FFFF;
  localparam logic [36:0] P_LIM = 37'h10_0000_0000;

  localparam logic [1:0] CFG_TEMP = 2'd0;
  localparam logic [1:0] CFG_PRESS_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_B = 2'd2;
  localparam logic [1:0] CFG_PRESS_C = 2'd3;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [24:0]        pressure_q8;
    logic               pressure_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [14:0] tc;
    logic [19:0]        ap;
  } temp_res_t;

  typedef struct packed {
    logic signed [63:0] num;
    logic signed [41:0] den;
    logic signed [14:0] tc;
  } poly_res_t;

  typedef struct packed {
    logic signed [14:0] tc;
    logic               dz;
    logic               neg;
  } div_tag_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] qmag;
    logic                ovf;
    div_tag_t            tag;
  } div_res_t;

endpackage

// ===== src/ptc_temp.sv =====
// Temperature stages: fine temperature, 0.01 degC result and pressure offset x.
// Depends on ptc_pkg.
module ptc_temp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  ptc_pkg::in_item_t in_item,
  input  ptc_pkg::cal_t     cal,
  output logic              valid_o,
  output ptc_pkg::temp_res_t res_o
);
  import ptc_pkg::*;

  logic [4:0]         vld_r;
  logic signed [17:0] d1_r;
  logic signed [16:0] d2_r;
  logic signed [33:0] m1_r;
  logic signed [33:0] sq_r;
  logic signed [22:0] m1s_r;
  logic signed [37:0] m2_r;
  logic signed [23:0] fine_r;
  logic [19:0]        ap1_r, ap2_r, ap3_r, ap4_r;
  temp_res_t          res_r;
  logic signed [26:0] tc_wide;
  logic signed [14:0] tc_sat;

  always_comb begin
    tc_wide = (27'(fine_r) * 27'sd5 + 27'sd128) >>> 8;
    if (tc_wide < 27'(TEMP_MIN)) begin
      tc_sat = 15'(TEMP_MIN);
    end else if (tc_wide > 27'(TEMP_MAX)) begin
      tc_sat = 15'(TEMP_MAX);
    end else begin
      tc_sat = 15'(tc_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= $signed({1'b0, in_item.adc_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      d2_r  <= $signed({1'b0, in_item.adc_temperature[19:4]}) - $signed({1'b0, cal.t1});
      ap1_r <= in_item.adc_pressure;
      m1_r  <= 34'(d1_r) * 34'($signed(cal.t2));
      sq_r  <= 34'(d2_r) * 34'(d2_r);
      ap2_r <= ap1_r;
      m1s_r <= 23'(m1_r >>> 11);
      m2_r  <= 38'($signed({1'b0, sq_r[32:12]})) * 38'($signed(cal.t3));
      ap3_r <= ap2_r;
      fine_r <= 24'(m1s_r) + 24'(m2_r >>> 14);
      ap4_r <= ap3_r;
      res_r.x  <= fine_r - 24'sd128000;
      res_r.tc <= tc_sat;
      res_r.ap <= ap4_r;
    end
  end

  assign valid_o = vld_r[4];
  assign res_o   = res_r;

endmodule

// ===== src/ptc_poly.sv =====
// Polynomial stages: pressure numerator and divisor from x and the raw pressure.
// Depends on ptc_pkg.
module ptc_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  ptc_pkg::temp_res_t res_i,
  input  ptc_pkg::cal_t      cal,
  output logic               valid_o,
  output ptc_pkg::poly_res_t res_o
);
  import ptc_pkg::*;

  localparam logic signed [55:0] Y_BIAS = 56'sd1 <<< 47;

  logic [4:0]         vld_r;
  logic signed [46:0] xx_r;
  logic signed [39:0] xp5_r, xp2_r, xp5b_r, xp2b_r;
  logic signed [63:0] a6_r, a3_r, w_r;
  logic signed [55:0] y_r;
  logic signed [40:0] qp1_r;
  logic [48:0]        rp1_r;
  logic signed [63:0] num_r;
  logic signed [14:0] tc1_r, tc2_r, tc3_r, tc4_r;
  logic [19:0]        ap1_r, ap2_r, ap3_r;
  poly_res_t          res_r;
  logic [20:0]        nbase;

  assign nbase = 21'h10_0000 - {1'b0, ap3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r   <= 47'(res_i.x) * 47'(res_i.x);
      xp5_r  <= 40'(res_i.x) * 40'($signed(cal.p5));
      xp2_r  <= 40'(res_i.x) * 40'($signed(cal.p2));
      tc1_r  <= res_i.tc;
      ap1_r  <= res_i.ap;
      a6_r   <= 64'(xx_r) * 64'($signed(cal.p6));
      a3_r   <= 64'(xx_r) * 64'($signed(cal.p3));
      xp5b_r <= xp5_r;
      xp2b_r <= xp2_r;
      tc2_r  <= tc1_r;
      ap2_r  <= ap1_r;
      w_r    <= a6_r + (64'(xp5b_r) <<< 17) + (64'($signed(cal.p4)) <<< 35);
      y_r    <= 56'(a3_r >>> 8) + (56'(xp2b_r) <<< 12) + Y_BIAS;
      tc3_r  <= tc2_r;
      ap3_r  <= ap2_r;
      qp1_r  <= 41'($signed(y_r[55:33])) * 41'($signed({1'b0, cal.p1}));
      rp1_r  <= 49'(y_r[32:0]) * 49'(cal.p1);
      num_r  <= $signed(64'(nbase) << 31) - w_r;
      tc4_r  <= tc3_r;
      res_r.den <= 42'(qp1_r) + 42'($signed({1'b0, rp1_r[48:33]}));
      res_r.num <= num_r;
      res_r.tc  <= tc4_r;
    end
  end

  assign valid_o = vld_r[4];
  assign res_o   = res_r;

endmodule

// ===== src/ptc_div.sv =====
// Pipelined restoring divider: magnitude of num * 3125 / den plus an
// overflow flag, one quotient bit per stage. Depends on ptc_pkg.
module ptc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  ptc_pkg::poly_res_t res_i,
  output logic               valid_o,
  output ptc_pkg::div_res_t  res_o
);
  import ptc_pkg::*;

  localparam int NSTG = DIV_BITS + 4;

  logic [NSTG-1:0]     vld_r;
  logic [62:0]         na_r;
  logic [40:0]         da0_r, da1_r, da2_r;
  div_tag_t            tag0_r, tag1_r, tag2_r;
  logic [75:0]         s1_r, s2_r, n_r;
  logic [63:0]         na_full;
  logic [41:0]         da_full;

  logic [41:0]         rem_r [0:DIV_BITS];
  logic [DIV_BITS-1:0] nlo_r [0:DIV_BITS];
  logic [DIV_BITS-1:0] q_r   [0:DIV_BITS];
  logic [40:0]         da_r  [0:DIV_BITS];
  div_tag_t            tag_r [0:DIV_BITS];
  logic                ovf_r [0:DIV_BITS];

  assign na_full = res_i.num[63] ? 64'(-res_i.num) : 64'(res_i.num);
  assign da_full = res_i.den[41] ? 42'(-res_i.den) : 42'(res_i.den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r        <= na_full[62:0];
      da0_r       <= da_full[40:0];
      tag0_r.tc   <= res_i.tc;
      tag0_r.dz   <= (res_i.den == '0);
      tag0_r.neg  <= res_i.num[63] ^ res_i.den[41];
      s1_r   <= (76'(na_r) << 11) + (76'(na_r) << 10) + (76'(na_r) << 5);
      s2_r   <= (76'(na_r) << 4) + (76'(na_r) << 2) + 76'(na_r);
      da1_r  <= da0_r;
      tag1_r <= tag0_r;
      n_r    <= s1_r + s2_r;
      da2_r  <= da1_r;
      tag2_r <= tag1_r;
      ovf_r[0] <= 78'(n_r) >= (78'(da2_r) << DIV_BITS);
      rem_r[0] <= 42'(n_r[75:DIV_BITS]);
      nlo_r[0] <= n_r[DIV_BITS-1:0];
      q_r[0]   <= '0;
      da_r[0]  <= da2_r;
      tag_r[0] <= tag2_r;
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
    logic [41:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1][40:0], nlo_r[k-1][DIV_BITS-1]};
    assign ge    = trial >= {1'b0, da_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? trial - {1'b0, da_r[k-1]} : trial;
        nlo_r[k] <= nlo_r[k-1] << 1;
        q_r[k]   <= {q_r[k-1][DIV_BITS-2:0], ge};
        da_r[k]  <= da_r[k-1];
        tag_r[k] <= tag_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign valid_o   = vld_r[NSTG-1];
  assign res_o.qmag = q_r[DIV_BITS];
  assign res_o.ovf  = ovf_r[DIV_BITS];
  assign res_o.tag  = tag_r[DIV_BITS];

endmodule

// ===== src/ptc_post.sv =====
// Pressure correction stages and the output register of the result channel.
// Depends on ptc_pkg.
module ptc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  ptc_pkg::div_res_t  res_i,
  input  ptc_pkg::cal_t      cal,
  output logic               out_valid,
  output ptc_pkg::out_item_t out_item
);
  import ptc_pkg::*;

  logic [3:0]         vld_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic signed [37:0] p0_r, p1_r, p2_r;
  logic signed [47:0] ss_r;
  logic signed [53:0] e2m_r;
  logic signed [63:0] e1m_r;
  logic signed [34:0] e2_r;
  logic signed [39:0] sum_r;
  div_tag_t           tag0_r, tag1_r, tag2_r, tag3_r;
  logic [36:0]        pm;
  logic signed [24:0] s;
  logic signed [40:0] pr;

  assign pm = (res_i.ovf || res_i.qmag > P_LIM) ? P_LIM : res_i.qmag;
  assign s  = $signed(p0_r[37:13]);
  assign pr = 41'(sum_r >>> 8) + (41'($signed(cal.p7)) <<< 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[2:0], valid_i};
      out_valid_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= res_i.tag.neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
      tag0_r <= res_i.tag;
      ss_r   <= 48'(s) * 48'(s);
      e2m_r  <= 54'(p0_r) * 54'($signed(cal.p8));
      p1_r   <= p0_r;
      tag1_r <= tag0_r;
      e1m_r  <= 64'(ss_r) * 64'($signed(cal.p9));
      e2_r   <= 35'(e2m_r >>> 19);
      p2_r   <= p1_r;
      tag2_r <= tag1_r;
      sum_r  <= 40'(p2_r) + 40'(e1m_r >>> 25) + 40'(e2_r);
      tag3_r <= tag2_r;
      out_item_r.temperature_centi <= tag3_r.tc;
      out_item_r.pressure_valid    <= !tag3_r.dz;
      if (tag3_r.dz || pr < 41'sd0) begin
        out_item_r.pressure_q8 <= '0;
      end else if (pr > $signed({16'd0, PRESS_MAX})) begin
        out_item_r.pressure_q8 <= PRESS_MAX;
      end else begin
        out_item_r.pressure_q8 <= 25'(pr);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/pressure_temperature_compensation_unit.sv =====
// Top level of the pressure and temperature compensation unit.
// Depends on ptc_pkg, ptc_temp, ptc_poly, ptc_div and ptc_post.
//
//   Channel  Ports                              Direction
//   in       in_valid, in_stall, in_item        reading pairs in
//   out      out_valid, out_stall, out_item     compensated results out
//   cfg      cfg_wr_en, cfg_index, cfg_wdata    calibration writes
//
// One transaction enters per cycle while in_stall is low.
// Most of the pipeline depth is the 37 one-bit stages of the quotient divider.
// Reset clears all valid bits and the calibration registers.
// A result held by out_stall freezes the whole pipeline and raises in_stall.
module pressure_temperature_compensation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ptc_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import ptc_pkg::*;

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  cal_t        cal;
  logic        en;
  logic        t_valid, p_valid, d_valid;
  temp_res_t   t_res;
  poly_res_t   p_res;
  div_res_t    d_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEMP:    temp_cal_r <= cfg_wdata[47:0];
        CFG_PRESS_A: press_a_r  <= cfg_wdata;
        CFG_PRESS_B: press_b_r  <= cfg_wdata;
        CFG_PRESS_C: press_c_r  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_a_r[15:0];
    cal.p2 = press_a_r[31:16];
    cal.p3 = press_a_r[47:32];
    cal.p4 = press_a_r[63:48];
    cal.p5 = press_b_r[15:0];
    cal.p6 = press_b_r[31:16];
    cal.p7 = press_b_r[47:32];
    cal.p8 = press_b_r[63:48];
    cal.p9 = press_c_r;
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  ptc_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .cal      (cal),
    .valid_o  (t_valid),
    .res_o    (t_res)
  );

  ptc_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (t_valid),
    .res_i   (t_res),
    .cal     (cal),
    .valid_o (p_valid),
    .res_o   (p_res)
  );

  ptc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (p_valid),
    .res_i   (p_res),
    .valid_o (d_valid),
    .res_o   (d_res)
  );

  ptc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (d_valid),
    .res_i     (d_res),
    .cal       (cal),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== src/ptc_checker.sv =====
// Port-level checker of the compensation unit and its bind to the top level.
// Depends on ptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ptc_pkg::out_item_t out_item
);
  import ptc_pkg::*;

  `PTC_ASSERT(a_out_hold,
              out_valid && out_stall |=> out_valid && $stable(out_item),
              "stalled result changed")
  `PTC_ASSERT(a_in_free, !out_stall |-> !in_stall, "input stalled while output drains")
  `PTC_ASSERT(a_press_zero,
              out_valid && !out_item.pressure_valid |-> out_item.pressure_q8 == 25'd0,
              "invalid pressure not zero")
  `PTC_ASSERT(a_temp_range,
              out_valid |-> (out_item.temperature_centi >= -15'sd4000)
                            && (out_item.temperature_centi <= 15'sd8500),
              "temperature out of range")
  `PTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench of the pressure and temperature compensation unit.
// Depends on ptc_pkg and pressure_temperature_compensation_unit; it predicts every
// result in fixed point, compares it field by field and applies random idling.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int LATENCY = 55;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [63:0] cfg_wdata;

  logic [47:0] temp_cal;
  logic [63:0] press_cal_a;
  logic [63:0] press_cal_b;
  logic [15:0] press_cal_c;

  out_item_t expected_results[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  logic hold_go;
  logic hold_seen;
  int hold_left;

  pressure_temperature_compensation_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_item_t compensate(in_item_t rd);
    longint at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d1, d2, fine, tc, x, w, y, q, r, den, num, qx, rx, p, s, e1, e2, press;
    out_item_t res;
    at = longint'(rd.adc_temperature);
    ap = longint'(rd.adc_pressure);
    t1 = longint'(temp_cal[15:0]);
    t2 = longint'($signed(temp_cal[31:16]));
    t3 = longint'($signed(temp_cal[47:32]));
    p1 = longint'(press_cal_a[15:0]);
    p2 = longint'($signed(press_cal_a[31:16]));
    p3 = longint'($signed(press_cal_a[47:32]));
    p4 = longint'($signed(press_cal_a[63:48]));
    p5 = longint'($signed(press_cal_b[15:0]));
    p6 = longint'($signed(press_cal_b[31:16]));
    p7 = longint'($signed(press_cal_b[47:32]));
    p8 = longint'($signed(press_cal_b[63:48]));
    p9 = longint'($signed(press_cal_c));
    d1 = (at >>> 3) - 2 * t1;
    d2 = (at >>> 4) - t1;
    fine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
    tc = sat((fine * 5 + 128) >>> 8, TEMP_MIN, TEMP_MAX);
    x = fine - 128000;
    w = x * x * p6 + x * p5 * 131072 + p4 * (64'sd1 <<< 35);
    y = ((x * x * p3) >>> 8) + x * p2 * 4096 + (64'sd1 <<< 47);
    q = y >>> 33;
    r = y - q * (64'sd1 <<< 33);
    den = q * p1 + ((r * p1) >>> 33);
    res.temperature_centi = tc[14:0];
    if (den == 0) begin
      res.pressure_q8 = '0;
      res.pressure_valid = 1'b0;
    end else begin
      num = (1048576 - ap) * (64'sd1 <<< 31) - w;
      qx = num / den;
      rx = num % den;
      if (qx > (64'sd1 <<< 36)) begin
        p = 64'sd1 <<< 36;
      end else if (qx < -(64'sd1 <<< 36)) begin
        p = -(64'sd1 <<< 36);
      end else begin
        p = sat(qx * 3125 + (rx * 3125) / den, -(64'sd1 <<< 36), 64'sd1 <<< 36);
      end
      s = p >>> 13;
      e1 = (p9 * s * s) >>> 25;
      e2 = (p8 * p) >>> 19;
      press = sat(((p + e1 + e2) >>> 8) + p7 * 16, 0, 33554431);
      res.pressure_q8 = press[24:0];
      res.pressure_valid = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Expectations are formed as each input transaction is accepted.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(compensate(in_item));
    end
  end

  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Unexpected result %h", out_item);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.temperature_centi !== exp_res.temperature_centi
            || out_item.pressure_q8 !== exp_res.pressure_q8
            || out_item.pressure_valid !== exp_res.pressure_valid) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Mismatch: temp %0d/%0d press %h/%h valid %b/%b (exp/act)",
                     exp_res.temperature_centi, out_item.temperature_centi,
                     exp_res.pressure_q8, out_item.pressure_q8,
                     exp_res.pressure_valid, out_item.pressure_valid);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  task automatic send_reading(input logic [19:0] adc_t, input logic [19:0] adc_p);
    logic stalled;
    in_valid <= 1'b1;
    in_item.adc_temperature <= adc_t;
    in_item.adc_pressure <= adc_p;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_cal(input logic [1:0] idx, input logic [63:0] data);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_TEMP: temp_cal = data[47:0];
      CFG_PRESS_A: press_cal_a = data;
      CFG_PRESS_B: press_cal_b = data;
      default: press_cal_c = data[15:0];
    endcase
  endtask

  task automatic load_typical_cal;
    write_cal(CFG_TEMP, {16'hFC18, 16'd26435, 16'd27504});
    write_cal(CFG_PRESS_A, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
    write_cal(CFG_PRESS_B, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
    write_cal(CFG_PRESS_C, 64'd6000);
  endtask

  task automatic send_random_readings(input int count, input int typical_pct);
    repeat (count) begin
      if ($urandom_range(99) < typical_pct) begin
        send_reading(20'($urandom_range(560000, 480000)),
                     20'($urandom_range(500000, 250000)));
      end else begin
        send_reading(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
      end
    end
  endtask

  task automatic test_zero_divisor;
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd519888, 20'd415148);
  endtask

  task automatic test_directed_extremes;
    load_typical_cal();
    send_reading(20'd519888, 20'd415148);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h80000, 20'h7FFFF);
    send_reading(20'd519888, 20'h00001);
    send_reading(20'd519888, 20'hFFFFE);
    write_cal(CFG_PRESS_C, 64'h8000);
    write_cal(CFG_TEMP, {16'h7FFF, 16'h8000, 16'hFFFF});
    send_reading(20'h00000, 20'd415148);
    send_reading(20'hFFFFF, 20'd415148);
    write_cal(CFG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(CFG_PRESS_B, 64'h7FFF_7FFF_7FFF_7FFF);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'hFFFFF, 20'h00000);
    write_cal(CFG_PRESS_B, 64'h8000_8000_8000_8000);
    send_reading(20'h00000, 20'hFFFFF);
  endtask

  task automatic test_random_calibration;
    repeat (4) begin
      write_cal(CFG_TEMP, {$urandom, $urandom});
      write_cal(CFG_PRESS_A, {$urandom, $urandom});
      write_cal(CFG_PRESS_B, {$urandom, $urandom});
      write_cal(CFG_PRESS_C, {$urandom, $urandom});
      send_random_readings(10, 50);
    end
  endtask

  task automatic test_random_idling;
    load_typical_cal();
    send_idle_pct = 8;
    recv_idle_pct = 86;
    send_random_readings(90, 80);
    send_idle_pct = 86;
    recv_idle_pct = 8;
    send_random_readings(90, 80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_readings(90, 80);
  endtask

  task automatic test_output_hold;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go <= ~hold_go;
    send_random_readings(100, 80);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TEMP;
    cfg_wdata = '0;
    hold_go = 1'b0;
    temp_cal = '0;
    press_cal_a = '0;
    press_cal_b = '0;
    press_cal_c = '0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_divisor();
    test_directed_extremes();
    test_random_calibration();
    test_random_idling();
    test_output_hold();
    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
